FILE: hdl/lss_pkg.sv
// Shared types, codes and helpers for the line substring search block.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package lss_pkg;

  // Operation codes carried by each input beat
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_BYTE   = 2'd2,
    OP_EOL    = 2'd3
  } op_t;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SEL = 1'b1;

  // Result position field width
  localparam int POS_W = 10;

  // Fold ASCII upper case to lower case when enabled
  function automatic logic [7:0] fold(input logic en, input logic [7:0] c);
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lss_in_if.sv
// Input channel of the line substring search block: operation and byte.
// Depends on lss_pkg.
`default_nettype none

interface lss_in_if
  import lss_pkg::*;
;
  logic       valid;
  logic       ready;
  op_t        operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/lss_out_if.sv
// Result channel of the line substring search block: one beat per line.
// Depends on lss_pkg.
`default_nettype none

interface lss_out_if
  import lss_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             selected;
  logic             found;
  logic [POS_W-1:0] match_position;
  logic             line_overflow;

  modport source (output valid, output selected, output found, output match_position,
                  output line_overflow, input ready);
  modport sink   (input valid, input selected, input found, input match_position,
                  input line_overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/line_substring_search.sv
// Top level of the line substring search block: pattern cells, line state, result register.
// Depends on lss_pkg, lss_in_if and lss_out_if.
//
// Usage:
//   line_in carries one beat per operation: clear pattern, append a pattern byte,
//   a line byte, or end of line. Load the pattern first, then stream line bytes.
//   Each end-of-line beat yields exactly one beat on result: found, selected
//   (found XOR the invert flag), the leftmost start position and an overflow flag.
//   Other beats yield nothing.
//   The pattern sits in a row of PATTERN_MAX cells; each cell compares its own
//   stored byte with the incoming line byte and shifts the partial-match bit of its
//   left neighbor, so the cost of a line byte does not depend on the pattern length.
//   Throughput: one beat per cycle while the receiver does not stall. The result beat
//   shows in the cycle after the end-of-line beat is accepted.
//   The result register is the only buffer. line_in stays ready while that
//   register is empty or being drained in the same cycle; when the receiver
//   stalls with a result pending, line_in holds ready low.
//   Reset (rst, synchronous) clears pattern length, line state, flags, the
//   configuration registers and the result valid; pattern bytes are not cleared
//   and are only read below the pattern length. No clearing pass is needed.
//   Write cfg_* only while the block is idle.
`default_nettype none

module line_substring_search
  import lss_pkg::*;
#(
  parameter int PATTERN_MAX = 256,
  parameter int LINE_MAX    = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lss_in_if.sink                     line_in,
  lss_out_if.source                  result
);

  localparam int PLW = $clog2(PATTERN_MAX + 1);          // pattern length width
  localparam int LCW = $clog2(LINE_MAX + 1);             // line count width
  localparam int SW  = ((LCW > PLW) ? LCW : PLW) + 1;    // start position arithmetic

  // Configuration registers
  logic fold_case;
  logic invert_sel;

  // Pattern cells and line state
  logic [7:0]             pattern_store [PATTERN_MAX];
  logic [PLW-1:0]         pattern_length;
  logic [PATTERN_MAX-1:0] partial_match;
  logic [PATTERN_MAX-1:0] partial_match_next;
  logic [PATTERN_MAX-1:0] below_len;   // cell index below the pattern length
  logic [PATTERN_MAX-1:0] last_cell;   // cell holding the final pattern byte
  logic [LCW-1:0]         line_count;
  logic                   found_flag;
  logic [POS_W-1:0]       first_position;
  logic                   overflow_flag;

  // Result register
  logic             res_valid;
  logic             res_selected;
  logic             res_found;
  logic [POS_W-1:0] res_position;
  logic             res_overflow;

  logic             accept;
  logic [7:0]       line_char;
  logic             line_full;
  logic             full_match;
  logic [SW-1:0]    start_full;
  logic [SW+POS_W-1:0] start_ext;
  logic             eol_found;

  // Take a new beat whenever the result slot is free or draining now
  assign line_in.ready = !res_valid || result.ready;
  assign accept        = line_in.valid && line_in.ready;

  assign line_char = fold(fold_case, line_in.byte_value);
  assign line_full = (line_count >= LCW'(LINE_MAX));

  // One compare per cell: advance the partial-match bit from the left neighbor
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = partial_match[i-1];
    end
    assign below_len[i] = (PLW'(i) < pattern_length);
    assign last_cell[i] = (PLW'(i + 1) == pattern_length);
    assign partial_match_next[i] = below_len[i] && prev &&
                                   (fold(fold_case, pattern_store[i]) == line_char);

    // Pattern byte lands in the cell at the current length
    always_ff @(posedge clk) begin
      if (accept && line_in.operation == OP_APPEND && pattern_length == PLW'(i)) begin
        pattern_store[i] <= line_in.byte_value;
      end
    end
  end

  // Whole pattern completes at this byte
  assign full_match = |(partial_match_next & last_cell);

  // Start index = count + 1 - length, kept to the low position bits
  assign start_full = SW'(line_count) + SW'(1) - SW'(pattern_length);
  assign start_ext  = {{POS_W{1'b0}}, start_full};

  assign eol_found = (pattern_length == '0) || found_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_case      <= 1'b0;
      invert_sel     <= 1'b0;
      pattern_length <= '0;
      partial_match  <= '0;
      line_count     <= '0;
      found_flag     <= 1'b0;
      first_position <= '0;
      overflow_flag  <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FOLD_CASE:  fold_case  <= cfg_data[0];
          CFG_INVERT_SEL: invert_sel <= cfg_data[0];
          default: ;
        endcase
      end

      // Load the result slot on an accepted end of line, drop it once taken
      if (accept && line_in.operation == OP_EOL) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if (accept) begin
        unique case (line_in.operation)
          OP_CLEAR: begin
            pattern_length <= '0;
            partial_match  <= '0;
          end
          OP_APPEND: begin
            if (pattern_length < PLW'(PATTERN_MAX)) begin
              pattern_length <= pattern_length + PLW'(1);
            end
            partial_match <= '0;
          end
          OP_BYTE: begin
            if (line_full) begin
              overflow_flag <= 1'b1;
            end else begin
              partial_match <= partial_match_next;
              line_count    <= line_count + LCW'(1);
              if (pattern_length != '0 && full_match && !found_flag) begin
                found_flag     <= 1'b1;
                first_position <= start_ext[POS_W-1:0];
              end
            end
          end
          OP_EOL: begin
            partial_match  <= '0;
            line_count     <= '0;
            found_flag     <= 1'b0;
            first_position <= '0;
            overflow_flag  <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result payload; hold while stalled since it loads only on an accepted end of line
  always_ff @(posedge clk) begin
    if (accept && line_in.operation == OP_EOL) begin
      res_found    <= eol_found;
      res_selected <= eol_found ^ invert_sel;
      res_position <= (pattern_length != '0 && found_flag) ? first_position : '0;
      res_overflow <= overflow_flag;
    end
  end

  assign result.valid          = res_valid;
  assign result.selected       = res_selected;
  assign result.found          = res_found;
  assign result.match_position = res_position;
  assign result.line_overflow  = res_overflow;

  // An accepted end of line always presents a result next cycle
  a_eol_result : assert property (@(posedge clk) disable iff (rst)
    (accept && line_in.operation == OP_EOL) |=> res_valid)
    else $error("end of line accepted without a result");

  // Cells at or beyond the pattern length never hold a partial match
  a_pm_bounded : assert property (@(posedge clk) disable iff (rst)
    (partial_match & ~below_len) == '0)
    else $error("partial match beyond pattern length");

  // Overflow only once the line count has reached its maximum
  a_overflow_full : assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (line_count == LCW'(LINE_MAX)))
    else $error("overflow flagged below line maximum");

  // A line without a match reports position zero
  a_nofind_pos : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_position == '0))
    else $error("nonzero position on a line without a match");

endmodule

`default_nettype wire
